/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL of the circle arc vertex generator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

/* hw/rtl/cavg_pkg.sv */
// ----------------------------------------------------------------------------
// cavg_pkg
// Shared types, constants and the quarter-wave sine table builder.
// ----------------------------------------------------------------------------
`default_nettype none

package cavg_pkg;

   localparam int MAX_PAIRS    = 61;
   localparam int INDEX_W      = 6;
   localparam int ANGLE_W      = 10;
   localparam int OUT_ANGLE_W  = 9;
   localparam int DEG_W        = 7;
   localparam int QUARTER_LAST = 90;
   localparam int TRIG_MAG_W   = 17;
   localparam int FIELD_W      = 24;
   localparam int RADIUS_W     = 23;
   localparam int ARC_W        = 9;

   localparam int FULL_TURN    = 360;
   localparam int HALF_TURN    = 180;
   localparam int THREE_QUART  = 270;
   localparam int QUARTER_TURN = 90;
   localparam int ARC_START    = 90;
   localparam int ARC_END_BASE = 450;

   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam longint          ONE_Q30 = 64'sd1073741824;

   typedef enum logic [0:0] {
      OP_FULL    = 1'b0,
      OP_PARTIAL = 1'b1
   } op_type;

   // per-vertex data that travels down the pipeline
   typedef struct packed {
      logic [INDEX_W-1:0]         index;
      logic                       last;
      logic signed [FIELD_W-1:0]  center_x;
      logic signed [FIELD_W-1:0]  center_y;
      logic [RADIUS_W-1:0]        radius;
   } tag_type;

   // folded angle: first-quadrant index plus sign
   typedef struct packed {
      logic [DEG_W-1:0] deg;
      logic             neg;
   } fold_type;

   typedef logic [TRIG_MAG_W-1:0] quarter_table_type [0:QUARTER_LAST];

   // term times x squared, both in q30
   function automatic longint unsigned times_x2(input longint unsigned term,
                                               input longint unsigned x);
      longint unsigned t;
      t = (term * x) >> 30;
      return (t * x) >> 30;
   endfunction

   // sin of d degrees (0..90) as unsigned Q30, taylor series
   function automatic longint unsigned quarter_sin_q30(input int unsigned d);
      longint unsigned x;
      longint unsigned term;
      longint          acc;
      x    = (longint'(d) * PI_Q30 + 64'd90) / 64'd180;
      term = x;
      acc  = longint'(x);
      // alternating terms up to x^19, each divided by (n-1)*n
      term = times_x2(term, x) / 64'd6;
      acc  = acc - longint'(term);
      term = times_x2(term, x) / 64'd20;
      acc  = acc + longint'(term);
      term = times_x2(term, x) / 64'd42;
      acc  = acc - longint'(term);
      term = times_x2(term, x) / 64'd72;
      acc  = acc + longint'(term);
      term = times_x2(term, x) / 64'd110;
      acc  = acc - longint'(term);
      term = times_x2(term, x) / 64'd156;
      acc  = acc + longint'(term);
      term = times_x2(term, x) / 64'd210;
      acc  = acc - longint'(term);
      term = times_x2(term, x) / 64'd272;
      acc  = acc + longint'(term);
      term = times_x2(term, x) / 64'd342;
      acc  = acc - longint'(term);
      if (acc < 0) begin
         acc = 0;
      end
      if (acc > ONE_Q30) begin
         acc = ONE_Q30;
      end
      return longint'(acc);
   endfunction

   // quarter-wave magnitude table in q1.frac_bits, rounded half up
   function automatic quarter_table_type quarter_table(input int frac_bits);
      quarter_table_type t;
      longint unsigned   v;
      for (int d = 0; d <= QUARTER_LAST; d++) begin
         v    = quarter_sin_q30(d);
         t[d] = TRIG_MAG_W'((v + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits));
      end
      return t;
   endfunction

   // fold an angle below 360 into the first quadrant
   function automatic fold_type fold_angle(input logic [OUT_ANGLE_W-1:0] a);
      fold_type f;
      if (a < OUT_ANGLE_W'(QUARTER_TURN)) begin
         f.deg = DEG_W'(a);
         f.neg = 1'b0;
      end else if (a < OUT_ANGLE_W'(HALF_TURN)) begin
         f.deg = DEG_W'(OUT_ANGLE_W'(HALF_TURN) - a);
         f.neg = 1'b0;
      end else if (a < OUT_ANGLE_W'(THREE_QUART)) begin
         f.deg = DEG_W'(a - OUT_ANGLE_W'(HALF_TURN));
         f.neg = 1'b1;
      end else begin
         f.deg = DEG_W'(OUT_ANGLE_W'(FULL_TURN) - a);
         f.neg = 1'b1;
      end
      return f;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/circle_arc_vertex_generator.sv */
// Circle arc vertex generator.
// The req_ channel takes one circle command (mode, center, radius, arc); the
// rsp_ channel returns its triangle-strip vertex pairs, one per transaction,
// each a rim point with the center, numbered from 0, last set on the final one.
// A full circle gives up to 61 pairs; a partial arc walks from 90 degrees and
// closes at 450 minus the arc.
// After a request is accepted, the sequencer registers the command and issues
// its pairs one per cycle while no pair is held by rsp_stall, feeding a
// five-stage trig and scale pipeline (fold, lookup, multiply, round, add and
// clamp).
// A command holds req_stall high while its pairs are issued; the next request
// is taken in the cycle after its last pair is issued.
// When rsp_stall is high with a pair waiting, the whole pipeline and the
// sequencer hold, so nothing is dropped or repeated.
// Synchronous reset empties the pipeline and returns the sequencer to idle.
// ----------------------------------------------------------------------------
// circle_arc_vertex_generator
// Top level: command sequencer, trig pipeline and scale pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module circle_arc_vertex_generator
   import cavg_pkg::*;
#(
   parameter int ANGLE_STEP         = 6,
   parameter int COORD_WIDTH        = 24,
   parameter int TRIG_FRACTION_BITS = 14
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic                          req_op,
   input  wire logic signed [FIELD_W-1:0]     req_center_x,
   input  wire logic signed [FIELD_W-1:0]     req_center_y,
   input  wire logic [RADIUS_W-1:0]           req_radius,
   input  wire logic [ARC_W-1:0]              req_arc_degrees,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic signed [FIELD_W-1:0]     rsp_rim_x,
   output      logic signed [FIELD_W-1:0]     rsp_rim_y,
   output      logic signed [FIELD_W-1:0]     rsp_strip_center_x,
   output      logic signed [FIELD_W-1:0]     rsp_strip_center_y,
   output      logic [INDEX_W-1:0]            rsp_vertex_index,
   output      logic                          rsp_last
);

   logic                         adv;
   logic                         seq_valid;
   logic [OUT_ANGLE_W-1:0]       seq_angle;
   tag_type                      seq_tag;
   logic                         trig_valid;
   logic [TRIG_FRACTION_BITS:0]  trig_cos_mag;
   logic                         trig_cos_neg;
   logic [TRIG_FRACTION_BITS:0]  trig_sin_mag;
   logic                         trig_sin_neg;
   tag_type                      trig_tag;
   logic [FIELD_W-1:0]           rim_x;
   logic [FIELD_W-1:0]           rim_y;
   logic [FIELD_W-1:0]           cen_x;
   logic [FIELD_W-1:0]           cen_y;

   // pipeline moves unless a finished pair is held by the receiver
   assign adv = !(rsp_valid && rsp_stall);

   // angle walk
   cavg_sequencer #(
      .ANGLE_STEP (ANGLE_STEP)
   ) u_sequencer (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_radius      (req_radius),
      .req_arc_degrees (req_arc_degrees),
      .out_valid       (seq_valid),
      .out_angle       (seq_angle),
      .out_tag         (seq_tag)
   );

   // cosine and sine lookup
   cavg_trig #(
      .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
   ) u_trig (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (seq_valid),
      .in_angle    (seq_angle),
      .in_tag      (seq_tag),
      .out_valid   (trig_valid),
      .out_cos_mag (trig_cos_mag),
      .out_cos_neg (trig_cos_neg),
      .out_sin_mag (trig_sin_mag),
      .out_sin_neg (trig_sin_neg),
      .out_tag     (trig_tag)
   );

   // radius scaling and center offset
   cavg_scale #(
      .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS),
      .COORD_WIDTH        (COORD_WIDTH)
   ) u_scale (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (trig_valid),
      .in_cos_mag   (trig_cos_mag),
      .in_cos_neg   (trig_cos_neg),
      .in_sin_mag   (trig_sin_mag),
      .in_sin_neg   (trig_sin_neg),
      .in_tag       (trig_tag),
      .out_valid    (rsp_valid),
      .out_rim_x    (rim_x),
      .out_rim_y    (rim_y),
      .out_center_x (cen_x),
      .out_center_y (cen_y),
      .out_index    (rsp_vertex_index),
      .out_last     (rsp_last)
   );

   assign rsp_rim_x          = signed'(rim_x);
   assign rsp_rim_y          = signed'(rim_y);
   assign rsp_strip_center_x = signed'(cen_x);
   assign rsp_strip_center_y = signed'(cen_y);

   // a taken command keeps the input stalled while its pairs are issued
   `ASSERT_NEXT(a_stall_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // the highest pair index only ever closes a strip
   `ASSERT_IMPLY(a_max_index_is_last, clock, reset,
      rsp_valid && (rsp_vertex_index == INDEX_W'(MAX_PAIRS - 1)), rsp_last)

   // pairs of one strip leave back to back with no bubble
   `ASSERT_NEXT(a_strip_no_gap, clock, reset, rsp_valid && !rsp_stall && !rsp_last, rsp_valid)

endmodule

`default_nettype wire

/* hw/rtl/cavg_sequencer.sv */
// ----------------------------------------------------------------------------
// cavg_sequencer
// Takes one circle command and walks its angles, one vertex per cycle while adv is high.
// ----------------------------------------------------------------------------
`default_nettype none

module cavg_sequencer
   import cavg_pkg::*;
#(
   parameter int ANGLE_STEP = 6
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic                          req_op,
   input  wire logic signed [FIELD_W-1:0]     req_center_x,
   input  wire logic signed [FIELD_W-1:0]     req_center_y,
   input  wire logic [RADIUS_W-1:0]           req_radius,
   input  wire logic [ARC_W-1:0]              req_arc_degrees,
   output      logic                          out_valid,
   output      logic [OUT_ANGLE_W-1:0]        out_angle,
   output      tag_type                       out_tag
);

   localparam int FULL_COUNT = FULL_TURN / ANGLE_STEP + 1;
   localparam int FULL_TOTAL = (FULL_COUNT > MAX_PAIRS) ? MAX_PAIRS : FULL_COUNT;

   logic                        busy_ff;
   op_type                      mode_ff;
   logic [ANGLE_W-1:0]          angle_ff;
   logic [OUT_ANGLE_W-1:0]      end_ff;
   logic [INDEX_W-1:0]          k_ff;
   logic signed [FIELD_W-1:0]   cx_ff;
   logic signed [FIELD_W-1:0]   cy_ff;
   logic [RADIUS_W-1:0]         radius_ff;
   logic                        out_valid_ff;
   logic [OUT_ANGLE_W-1:0]      out_angle_ff;
   tag_type                     out_tag_ff;

   logic                        accept;
   logic                        stepping;
   logic [OUT_ANGLE_W-1:0]      emit_angle;
   logic                        emit_last;
   logic [ARC_W-1:0]            arc_sat;
   logic [OUT_ANGLE_W-1:0]      end_in;
   logic [ANGLE_W-1:0]          angle_in;

   assign accept    = req_valid && !busy_ff;
   assign req_stall = busy_ff;

   // closing angle of a partial arc
   assign arc_sat = (req_arc_degrees > ARC_W'(FULL_TURN)) ? ARC_W'(FULL_TURN) : req_arc_degrees;
   assign end_in  = OUT_ANGLE_W'(ARC_END_BASE) - OUT_ANGLE_W'(arc_sat);
   assign angle_in = (op_type'(req_op) == OP_FULL) ? '0 : ANGLE_W'(ARC_START);

   // current vertex choice
   assign stepping = (angle_ff < ANGLE_W'(end_ff)) && (k_ff < INDEX_W'(MAX_PAIRS - 1));
   always_comb begin
      case (mode_ff)
         OP_FULL: begin
            emit_angle = angle_ff[OUT_ANGLE_W-1:0];
            emit_last  = (k_ff == INDEX_W'(FULL_TOTAL - 1));
         end
         OP_PARTIAL: begin
            emit_angle = stepping ? angle_ff[OUT_ANGLE_W-1:0] : end_ff;
            emit_last  = !stepping;
         end
         default: begin
            emit_angle = angle_ff[OUT_ANGLE_W-1:0];
            emit_last  = 1'b1;
         end
      endcase
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && adv && emit_last) begin
            busy_ff <= 1'b0;
         end
         if (adv) begin
            out_valid_ff <= busy_ff;
         end
      end
   end

   // command and walk registers
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= op_type'(req_op);
         angle_ff  <= angle_in;
         end_ff    <= end_in;
         k_ff      <= '0;
         cx_ff     <= req_center_x;
         cy_ff     <= req_center_y;
         radius_ff <= req_radius;
      end else if (busy_ff && adv) begin
         angle_ff <= angle_ff + ANGLE_W'(ANGLE_STEP);
         k_ff     <= k_ff + INDEX_W'(1);
      end
   end

   // issued vertex
   always_ff @(posedge clock) begin
      if (adv) begin
         out_angle_ff        <= emit_angle;
         out_tag_ff.index    <= k_ff;
         out_tag_ff.last     <= emit_last;
         out_tag_ff.center_x <= cx_ff;
         out_tag_ff.center_y <= cy_ff;
         out_tag_ff.radius   <= radius_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_angle = out_angle_ff;
   assign out_tag   = out_tag_ff;

endmodule

`default_nettype wire

/* hw/rtl/cavg_trig.sv */
// ----------------------------------------------------------------------------
// cavg_trig
// Two pipeline stages: angle reduction and folding, then table lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module cavg_trig
   import cavg_pkg::*;
#(
   parameter int TRIG_FRACTION_BITS = 14
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          in_valid,
   input  wire logic [OUT_ANGLE_W-1:0]        in_angle,
   input  wire tag_type                       in_tag,
   output      logic                          out_valid,
   output      logic [TRIG_FRACTION_BITS:0]   out_cos_mag,
   output      logic                          out_cos_neg,
   output      logic [TRIG_FRACTION_BITS:0]   out_sin_mag,
   output      logic                          out_sin_neg,
   output      tag_type                       out_tag
);

   localparam quarter_table_type QUARTER_TABLE = quarter_table(TRIG_FRACTION_BITS);

   logic [ANGLE_W-1:0]           s_ang;
   logic [ANGLE_W-1:0]           c_ang;
   logic [OUT_ANGLE_W-1:0]       s_red;
   logic [OUT_ANGLE_W-1:0]       c_red;
   fold_type                     s_fold_in;
   fold_type                     c_fold_in;

   logic                         v1_ff;
   fold_type                     s_fold_ff;
   fold_type                     c_fold_ff;
   tag_type                      tag1_ff;

   logic                         v2_ff;
   logic [TRIG_FRACTION_BITS:0]  cos_mag_ff;
   logic                         cos_neg_ff;
   logic [TRIG_FRACTION_BITS:0]  sin_mag_ff;
   logic                         sin_neg_ff;
   tag_type                      tag2_ff;

   // reduce mod 360; cosine is sine shifted by a quarter turn
   assign s_ang = ANGLE_W'(in_angle);
   assign c_ang = ANGLE_W'(in_angle) + ANGLE_W'(QUARTER_TURN);
   assign s_red = (s_ang >= ANGLE_W'(FULL_TURN)) ?
                  OUT_ANGLE_W'(s_ang - ANGLE_W'(FULL_TURN)) : OUT_ANGLE_W'(s_ang);
   assign c_red = (c_ang >= ANGLE_W'(FULL_TURN)) ?
                  OUT_ANGLE_W'(c_ang - ANGLE_W'(FULL_TURN)) : OUT_ANGLE_W'(c_ang);
   assign s_fold_in = fold_angle(s_red);
   assign c_fold_in = fold_angle(c_red);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   // stage 1: folded angles
   always_ff @(posedge clock) begin
      if (adv) begin
         s_fold_ff <= s_fold_in;
         c_fold_ff <= c_fold_in;
         tag1_ff   <= in_tag;
      end
   end

   // stage 2: table magnitudes
   always_ff @(posedge clock) begin
      if (adv) begin
         cos_mag_ff <= QUARTER_TABLE[c_fold_ff.deg][TRIG_FRACTION_BITS:0];
         cos_neg_ff <= c_fold_ff.neg;
         sin_mag_ff <= QUARTER_TABLE[s_fold_ff.deg][TRIG_FRACTION_BITS:0];
         sin_neg_ff <= s_fold_ff.neg;
         tag2_ff    <= tag1_ff;
      end
   end

   assign out_valid   = v2_ff;
   assign out_cos_mag = cos_mag_ff;
   assign out_cos_neg = cos_neg_ff;
   assign out_sin_mag = sin_mag_ff;
   assign out_sin_neg = sin_neg_ff;
   assign out_tag     = tag2_ff;

endmodule

`default_nettype wire

/* hw/rtl/cavg_scale.sv */
// ----------------------------------------------------------------------------
// cavg_scale
// Three pipeline stages: multiply by radius, round to q8, add center and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module cavg_scale
   import cavg_pkg::*;
#(
   parameter int TRIG_FRACTION_BITS = 14,
   parameter int COORD_WIDTH        = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          in_valid,
   input  wire logic [TRIG_FRACTION_BITS:0]   in_cos_mag,
   input  wire logic                          in_cos_neg,
   input  wire logic [TRIG_FRACTION_BITS:0]   in_sin_mag,
   input  wire logic                          in_sin_neg,
   input  wire tag_type                       in_tag,
   output      logic                          out_valid,
   output      logic [FIELD_W-1:0]            out_rim_x,
   output      logic [FIELD_W-1:0]            out_rim_y,
   output      logic [FIELD_W-1:0]            out_center_x,
   output      logic [FIELD_W-1:0]            out_center_y,
   output      logic [INDEX_W-1:0]            out_index,
   output      logic                          out_last
);

   localparam int PROD_W = TRIG_FRACTION_BITS + 1 + RADIUS_W;
   localparam int SUM_W  = FIELD_W + 1;
   localparam int EXT_W  = (COORD_WIDTH + 1 > SUM_W) ? COORD_WIDTH + 1 : SUM_W;
   localparam longint SAT_HI_L = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
   localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(SAT_HI_L);
   localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(-SAT_HI_L - 1);
   localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(1) << (TRIG_FRACTION_BITS - 1);

   // clamp to the coordinate range, keep the low field bits
   function automatic logic [FIELD_W-1:0] sat_coord(input logic signed [EXT_W-1:0] v);
      logic signed [EXT_W-1:0] c;
      if (v > SAT_HI) begin
         c = SAT_HI;
      end else if (v < SAT_LO) begin
         c = SAT_LO;
      end else begin
         c = v;
      end
      return c[FIELD_W-1:0];
   endfunction

   logic                         v3_ff;
   logic [PROD_W-1:0]            prod_x_ff;
   logic [PROD_W-1:0]            prod_y_ff;
   logic                         neg_x_ff;
   logic                         neg_y_ff;
   tag_type                      tag3_ff;

   logic [PROD_W:0]              rnd_x;
   logic [PROD_W:0]              rnd_y;
   logic signed [FIELD_W-1:0]    q_x;
   logic signed [FIELD_W-1:0]    q_y;

   logic                         v4_ff;
   logic signed [FIELD_W-1:0]    off_x_ff;
   logic signed [FIELD_W-1:0]    off_y_ff;
   tag_type                      tag4_ff;

   logic signed [SUM_W-1:0]      sum_x;
   logic signed [SUM_W-1:0]      sum_y;

   logic                         v5_ff;
   logic [FIELD_W-1:0]           rim_x_ff;
   logic [FIELD_W-1:0]           rim_y_ff;
   logic [FIELD_W-1:0]           cen_x_ff;
   logic [FIELD_W-1:0]           cen_y_ff;
   logic [INDEX_W-1:0]           index_ff;
   logic                         last_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= in_valid;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // stage 3: magnitude times radius
   always_ff @(posedge clock) begin
      if (adv) begin
         prod_x_ff <= PROD_W'(in_cos_mag) * PROD_W'(in_tag.radius);
         prod_y_ff <= PROD_W'(in_sin_mag) * PROD_W'(in_tag.radius);
         neg_x_ff  <= in_cos_neg;
         neg_y_ff  <= in_sin_neg;
         tag3_ff   <= in_tag;
      end
   end

   // round half away from zero on the magnitude, then apply sign
   assign rnd_x = (PROD_W + 1)'(prod_x_ff) + HALF;
   assign rnd_y = (PROD_W + 1)'(prod_y_ff) + HALF;
   assign q_x   = signed'(FIELD_W'(rnd_x >> TRIG_FRACTION_BITS));
   assign q_y   = signed'(FIELD_W'(rnd_y >> TRIG_FRACTION_BITS));

   // stage 4: signed offsets
   always_ff @(posedge clock) begin
      if (adv) begin
         off_x_ff <= neg_x_ff ? -q_x : q_x;
         off_y_ff <= neg_y_ff ? -q_y : q_y;
         tag4_ff  <= tag3_ff;
      end
   end

   // center plus offset
   assign sum_x = SUM_W'($signed(tag4_ff.center_x)) + SUM_W'(off_x_ff);
   assign sum_y = SUM_W'($signed(tag4_ff.center_y)) + SUM_W'(off_y_ff);

   // stage 5: clamped coordinates, output register
   always_ff @(posedge clock) begin
      if (adv) begin
         rim_x_ff <= sat_coord(EXT_W'(sum_x));
         rim_y_ff <= sat_coord(EXT_W'(sum_y));
         cen_x_ff <= sat_coord(EXT_W'($signed(tag4_ff.center_x)));
         cen_y_ff <= sat_coord(EXT_W'($signed(tag4_ff.center_y)));
         index_ff <= tag4_ff.index;
         last_ff  <= tag4_ff.last;
      end
   end

   assign out_valid    = v5_ff;
   assign out_rim_x    = rim_x_ff;
   assign out_rim_y    = rim_y_ff;
   assign out_center_x = cen_x_ff;
   assign out_center_y = cen_y_ff;
   assign out_index    = index_ff;
   assign out_last     = last_ff;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the circle arc vertex generator: circle commands go
// in through a bursty driver, and each returned vertex pair is compared against
// a strip predictor that rebuilds the sine table, the rounding and the clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import cavg_pkg::*;

   localparam int ANGLE_STEP   = 6;
   localparam int RANDOM_CMDS  = 88;
   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 24;

   typedef struct {
      op_type                    op;
      logic signed [FIELD_W-1:0] center_x;
      logic signed [FIELD_W-1:0] center_y;
      logic [RADIUS_W-1:0]       radius;
      logic [ARC_W-1:0]          arc;
   } circle_cmd_type;

   typedef struct {
      logic [FIELD_W-1:0] rim_x;
      logic [FIELD_W-1:0] rim_y;
      logic [FIELD_W-1:0] center_x;
      logic [FIELD_W-1:0] center_y;
      logic [INDEX_W-1:0] index;
      logic               last;
   } vertex_pair_type;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_op = OP_FULL;
   logic signed [FIELD_W-1:0]  req_center_x = '0;
   logic signed [FIELD_W-1:0]  req_center_y = '0;
   logic [RADIUS_W-1:0]        req_radius = '0;
   logic [ARC_W-1:0]           req_arc_degrees = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [FIELD_W-1:0]  rsp_rim_x;
   logic signed [FIELD_W-1:0]  rsp_rim_y;
   logic signed [FIELD_W-1:0]  rsp_strip_center_x;
   logic signed [FIELD_W-1:0]  rsp_strip_center_y;
   logic [INDEX_W-1:0]         rsp_vertex_index;
   logic                       rsp_last;

   circle_cmd_type  pending_cmds[$];
   vertex_pair_type expected_pairs[$];
   circle_cmd_type  next_cmd;
   circle_cmd_type  taken_cmd;
   vertex_pair_type want_pair;
   int             total_cmds = 0;
   int             accepted_cmds = 0;
   int             mismatch_count = 0;
   int             idle_cycles = 0;
   int             burst_left = 1;
   int             gap_left = 0;
   int             stall_phase_left = 0;
   int             stall_tick = 0;
   stall_mode_type stall_mode = STALL_NONE;
   bit             req_fire;
   bit             rsp_fire;

   circle_arc_vertex_generator #(
      .ANGLE_STEP(ANGLE_STEP)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_center_x       (req_center_x),
      .req_center_y       (req_center_y),
      .req_radius         (req_radius),
      .req_arc_degrees    (req_arc_degrees),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_rim_x          (rsp_rim_x),
      .rsp_rim_y          (rsp_rim_y),
      .rsp_strip_center_x (rsp_strip_center_x),
      .rsp_strip_center_y (rsp_strip_center_y),
      .rsp_vertex_index   (rsp_vertex_index),
      .rsp_last           (rsp_last)
   );

   // sin of deg degrees (0..90) as unsigned q30, taylor series up to x^19
   function automatic longint unsigned quarter_wave_q30(input int unsigned deg);
      longint unsigned x;
      longint unsigned term;
      longint          acc;
      bit              subtract;
      x        = (longint'(deg) * PI_Q30 + 64'd90) / 64'd180;
      term     = x;
      acc      = longint'(x);
      subtract = 1'b1;
      for (int n = 3; n <= 19; n += 2) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / longint'((n - 1) * n);
         acc  = subtract ? acc - longint'(term) : acc + longint'(term);
         subtract = !subtract;
      end
      if (acc < 0) begin
         acc = 0;
      end
      if (acc > ONE_Q30) begin
         acc = ONE_Q30;
      end
      return longint'(acc);
   endfunction

   // sine of any angle in q1.14, half-up rounding of the q30 value
   function automatic longint sine_q14(input int unsigned angle);
      int unsigned deg;
      int unsigned quad;
      int unsigned rem;
      longint      mag;
      deg  = angle % FULL_TURN;
      quad = deg / QUARTER_TURN;
      rem  = deg % QUARTER_TURN;
      mag  = longint'((quarter_wave_q30((quad & 1) ? QUARTER_TURN - rem : rem)
                       + (64'd1 << 15)) >> 16);
      return (quad >= 2) ? -mag : mag;
   endfunction

   // trig times radius, back to q8 with ties away from zero
   function automatic longint scale_to_q8(input longint trig, input longint rad);
      longint mag;
      mag = (trig < 0 ? -trig : trig) * rad;
      mag = (mag + 8192) >> 14;
      return (trig < 0) ? -mag : mag;
   endfunction

   function automatic longint clamp_coord(input longint v);
      longint hi;
      hi = (longint'(1) << (FIELD_W - 1)) - 1;
      if (v > hi) begin
         return hi;
      end
      if (v < -hi - 1) begin
         return -hi - 1;
      end
      return v;
   endfunction

   function automatic vertex_pair_type make_pair(input int k, input int unsigned angle,
                                                 input longint cx, input longint cy,
                                                 input longint rad, input bit last);
      vertex_pair_type p;
      p.rim_x    = FIELD_W'(clamp_coord(cx + scale_to_q8(sine_q14(angle + 90), rad)));
      p.rim_y    = FIELD_W'(clamp_coord(cy + scale_to_q8(sine_q14(angle), rad)));
      p.center_x = FIELD_W'(clamp_coord(cx));
      p.center_y = FIELD_W'(clamp_coord(cy));
      p.index    = INDEX_W'(k);
      p.last     = last;
      return p;
   endfunction

   // expand one circle command into its vertex pairs
   task automatic predict_strip(input circle_cmd_type c);
      longint      cx;
      longint      cy;
      longint      rad;
      int unsigned arc;
      int unsigned stop_angle;
      int unsigned angle;
      int          total;
      int          k;
      cx  = c.center_x;
      cy  = c.center_y;
      rad = c.radius;
      k   = 0;
      if (c.op == OP_FULL) begin
         total = FULL_TURN / ANGLE_STEP + 1;
         if (total > MAX_PAIRS) begin
            total = MAX_PAIRS;
         end
         for (k = 0; k < total; k++) begin
            expected_pairs = {expected_pairs,
                              make_pair(k, k * ANGLE_STEP, cx, cy, rad, k == total - 1)};
         end
      end else begin
         arc = (c.arc > FULL_TURN) ? FULL_TURN : c.arc;
         stop_angle = ARC_END_BASE - arc;
         angle = ARC_START;
         while (angle < stop_angle && k < MAX_PAIRS - 1) begin
            expected_pairs = {expected_pairs, make_pair(k, angle, cx, cy, rad, 1'b0)};
            angle += ANGLE_STEP;
            k++;
         end
         expected_pairs = {expected_pairs, make_pair(k, stop_angle, cx, cy, rad, 1'b1)};
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input int index,
                              input logic [FIELD_W-1:0] got,
                              input logic [FIELD_W-1:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("pair %0d %s got %h want %h", index, name, got, want));
      end
   endtask

   task automatic add_cmd(input op_type op, input logic signed [FIELD_W-1:0] cx,
                          input logic signed [FIELD_W-1:0] cy,
                          input logic [RADIUS_W-1:0] rad, input logic [ARC_W-1:0] arc);
      circle_cmd_type c;
      c.op       = op;
      c.center_x = cx;
      c.center_y = cy;
      c.radius   = rad;
      c.arc      = arc;
      pending_cmds = {pending_cmds, c};
      total_cmds++;
   endtask

   // random command with extra weight on small radii and the coordinate limits
   task automatic add_random_cmd();
      logic signed [FIELD_W-1:0] cx;
      logic signed [FIELD_W-1:0] cy;
      logic [RADIUS_W-1:0]       rad;
      logic [ARC_W-1:0]          arc;
      cx = FIELD_W'($urandom);
      cy = FIELD_W'($urandom);
      if ($urandom_range(0, 5) == 0) begin
         cx = $urandom_range(0, 1) ? 24'sh7FFFFF - FIELD_W'($urandom_range(0, 255))
                                   : 24'sh800000 + FIELD_W'($urandom_range(0, 255));
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3: rad = RADIUS_W'($urandom);
         4, 5, 6:    rad = RADIUS_W'($urandom_range(0, 4096));
         7:          rad = 23'h7FFFFF - RADIUS_W'($urandom_range(0, 1023));
         8:          rad = RADIUS_W'($urandom_range(0, 3)) << 13;
         default:    rad = RADIUS_W'($urandom_range(0, 15));
      endcase
      arc = ($urandom_range(0, 7) == 0) ? ARC_W'($urandom_range(0, 511))
                                        : ARC_W'($urandom_range(0, FULL_TURN));
      add_cmd(op_type'($urandom_range(0, 1)), cx, cy, rad, arc);
   endtask

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // stimulus, reset and end of run
   initial begin
      // directed: arc corners, saturation, rounding ties
      add_cmd(OP_FULL,    24'sh000000, 24'sh000000, 23'h000100, 9'd0);
      add_cmd(OP_FULL,    24'sh001234, -24'sh000800, 23'h000A00, 9'd0);
      add_cmd(OP_PARTIAL, 24'sh000100, 24'sh000200, 23'h001000, 9'd0);
      add_cmd(OP_PARTIAL, 24'sh000000, 24'sh000000, 23'h001000, 9'd1);
      add_cmd(OP_PARTIAL, 24'sh000000, 24'sh000000, 23'h001000, 9'd6);
      add_cmd(OP_PARTIAL, 24'sh000000, 24'sh000000, 23'h001000, 9'd90);
      add_cmd(OP_PARTIAL, 24'sh000000, 24'sh000000, 23'h001000, 9'd180);
      add_cmd(OP_PARTIAL, 24'sh000000, 24'sh000000, 23'h001000, 9'd270);
      add_cmd(OP_PARTIAL, 24'sh000000, 24'sh000000, 23'h001000, 9'd359);
      add_cmd(OP_PARTIAL, 24'sh000000, 24'sh000000, 23'h001000, 9'd360);
      add_cmd(OP_PARTIAL, 24'sh000000, 24'sh000000, 23'h001000, 9'd361);
      add_cmd(OP_PARTIAL, 24'sh000000, 24'sh000000, 23'h001000, 9'd511);
      add_cmd(OP_PARTIAL, -24'sh000001, 24'sh000001, 23'h000003, 9'd256);
      add_cmd(OP_FULL,    24'sh7FFFFF, 24'sh800000, 23'h000000, 9'd0);
      add_cmd(OP_FULL,    24'sh000000, 24'sh000000, 23'h7FFFFF, 9'd0);
      add_cmd(OP_FULL,    24'sh7FFFFF, 24'sh7FFFFF, 23'h7FFFFF, 9'd0);
      add_cmd(OP_FULL,    24'sh800000, 24'sh800000, 23'h7FFFFF, 9'd0);
      add_cmd(OP_PARTIAL, 24'sh7FFFFF, 24'sh800000, 23'h7FFFFF, 9'd45);
      add_cmd(OP_PARTIAL, -24'sh000001, -24'sh000001, 23'h000001, 9'd255);
      add_cmd(OP_FULL,    24'sh000000, 24'sh000000, 23'h000001, 9'd0);
      add_cmd(OP_FULL,    24'sh000000, 24'sh000000, 23'h002000, 9'd0);
      add_cmd(OP_PARTIAL, 24'sh400000, -24'sh400000, 23'h006000, 9'd300);
      for (int i = 0; i < RANDOM_CMDS; i++) begin
         add_random_cmd();
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // sampled on the falling edge so the checks see settled queues
      while (accepted_cmds < total_cmds) @(negedge clock);
      while (expected_pairs.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   // watchdog on cycles with no transaction on either channel
   initial begin
      while (idle_cycles < IDLE_LIMIT) @(negedge clock);
      $display("tb_top: FAIL");
      $finish;
   end

   // driver: bursts of commands with random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left != 0 || pending_cmds.size() == 0) begin
            req_valid <= 1'b0;
            if (gap_left != 0) begin
               gap_left = gap_left - 1;
            end
         end else begin
            next_cmd = pending_cmds.pop_front();
            req_valid       <= 1'b1;
            req_op          <= next_cmd.op;
            req_center_x    <= next_cmd.center_x;
            req_center_y    <= next_cmd.center_y;
            req_radius      <= next_cmd.radius;
            req_arc_degrees <= next_cmd.arc;
            burst_left = burst_left - 1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 6);
               case ($urandom_range(0, 3))
                  0:       gap_left = 0;
                  1:       gap_left = $urandom_range(1, 3);
                  default: gap_left = $urandom_range(1, 75);
               endcase
            end
         end
      end
   end

   // result side stall pattern, switching mode every so often
   always @(posedge clock) begin
      if (stall_phase_left == 0) begin
         stall_mode       = stall_mode_type'($urandom_range(0, 3));
         stall_phase_left = $urandom_range(10, 150);
      end else begin
         stall_phase_left = stall_phase_left - 1;
      end
      stall_tick = stall_tick + 1;
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 2) == 0);
         STALL_PERIODIC: rsp_stall <= ((stall_tick % 5) < 2);
         default:        rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // monitor: predict on accepted commands, check accepted vertex pairs
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         req_fire = req_valid && !req_stall;
         rsp_fire = rsp_valid && !rsp_stall;
         if (req_fire) begin
            taken_cmd.op       = op_type'(req_op);
            taken_cmd.center_x = req_center_x;
            taken_cmd.center_y = req_center_y;
            taken_cmd.radius   = req_radius;
            taken_cmd.arc      = req_arc_degrees;
            predict_strip(taken_cmd);
            accepted_cmds = accepted_cmds + 1;
         end
         if (rsp_fire) begin
            if (expected_pairs.size() == 0) begin
               report_mismatch($sformatf("unexpected vertex pair index %0d", rsp_vertex_index));
            end else begin
               want_pair = expected_pairs.pop_front();
               check_field("rim_x", want_pair.index, rsp_rim_x, want_pair.rim_x);
               check_field("rim_y", want_pair.index, rsp_rim_y, want_pair.rim_y);
               check_field("center_x", want_pair.index, rsp_strip_center_x,
                           want_pair.center_x);
               check_field("center_y", want_pair.index, rsp_strip_center_y,
                           want_pair.center_y);
               check_field("vertex_index", want_pair.index, FIELD_W'(rsp_vertex_index),
                           FIELD_W'(want_pair.index));
               check_field("last", want_pair.index, FIELD_W'(rsp_last),
                           FIELD_W'(want_pair.last));
            end
         end
         idle_cycles <= (req_fire || rsp_fire) ? 0 : idle_cycles + 1;
      end
   end

endmodule

`default_nettype wire
